// File: src/fsd_pkg.sv
// fsd_pkg: shared types and constants for the flame sweep detector
// operation codes, register indexes, sensing modes, direction classes, reset values
// no dependencies
`default_nettype none

package fsd_pkg;

  localparam int SAMPLE_BITS      = 12;
  localparam int DIRECTION_WINDOW = 20;

  localparam int ANGLE_W    = 8;
  localparam int STAMP_W    = 32;
  localparam int INTERVAL_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;

  typedef logic [ANGLE_W-1:0]     angle_t;
  typedef logic [STAMP_W-1:0]     stamp_t;
  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_SWEEP_EN  = 3'd1,
    OP_DETECT_EN = 3'd2,
    OP_CENTER    = 3'd3,
    OP_CLEAR     = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    REG_MIN_ANGLE    = 3'd0,
    REG_MAX_ANGLE    = 3'd1,
    REG_STEP_DEGREES = 3'd2,
    REG_STEP_INTERVAL = 3'd3,
    REG_FIRE_THRESHOLD = 3'd4,
    REG_SENSING_MODE = 3'd5,
    REG_CONFIRM_MS   = 3'd6,
    REG_DIR_CENTER   = 3'd7
  } cfg_reg_t;

  localparam logic [1:0] SENSE_AT_LEAST = 2'd0;
  localparam logic [1:0] SENSE_AT_MOST  = 2'd1;
  localparam logic [1:0] SENSE_DIGITAL  = 2'd2;

  localparam logic [1:0] DIR_NONE   = 2'd0;
  localparam logic [1:0] DIR_LEFT   = 2'd1;
  localparam logic [1:0] DIR_CENTER = 2'd2;
  localparam logic [1:0] DIR_RIGHT  = 2'd3;

  localparam angle_t             RST_MIN_ANGLE     = 8'd0;
  localparam angle_t             RST_MAX_ANGLE     = 8'd180;
  localparam angle_t             RST_STEP_DEGREES  = 8'd5;
  localparam logic [INTERVAL_W-1:0] RST_STEP_INTERVAL = 16'd50;
  localparam sample_t            RST_FIRE_THRESHOLD = SAMPLE_BITS'(500);
  localparam logic [1:0]         RST_SENSING_MODE  = SENSE_AT_LEAST;
  localparam logic [INTERVAL_W-1:0] RST_CONFIRM_MS = 16'd200;
  localparam angle_t             RST_DIR_CENTER    = 8'd90;

  // left / center / right class of an angle around the straight-ahead angle
  function automatic logic [1:0] class_of(input angle_t angle, input angle_t center);
    logic [ANGLE_W:0] lo_sum;
    logic [ANGLE_W:0] hi_sum;
    lo_sum = {1'b0, angle} + (ANGLE_W+1)'(DIRECTION_WINDOW);
    hi_sum = {1'b0, center} + (ANGLE_W+1)'(DIRECTION_WINDOW);
    if (lo_sum < {1'b0, center}) begin
      return DIR_LEFT;
    end else if ({1'b0, angle} > hi_sum) begin
      return DIR_RIGHT;
    end
    return DIR_CENTER;
  endfunction

endpackage

`default_nettype wire

// File: src/flame_sweep_detector.sv
// flame_sweep_detector: horizontal sweep control and confirmed flame detection
// top level, single module, one output register plus one skid register
// depends on fsd_pkg
//
// usage
//   s_axis carries one item per transfer: tuser is the operation code
//   (tick, sweep enable, detection enable, center, clear new-data), tdata
//   carries enable level, millisecond stamp, adc sample and pin level
//   m_axis returns exactly one result per input transfer: the scan angle,
//   detection status, direction class, latched angle, last reading and flags
//   as they stand after that item
//   cfg_we / cfg_index / cfg_data write the eight setup registers, only while
//   no transfer is in flight; writing either sweep end clamps the scan angle
// timing
//   the result is registered in the output register; one item per cycle sustained
//   while m_axis_tready is not held low, set by the single state update between
//   the input handshake and the result register (interval subtract, angle step,
//   class); the skid register lets one more item in while a result is stalled;
//   s_axis_tready drops only when both the output and skid registers are full
// reset
//   rst clears all state and loads the register defaults (sweep ends 0 / 180,
//   step 5, interval 50 ms, threshold 500, confirm 200 ms, center 90);
//   the scan angle rests at 180, sweep and detection start disabled
`default_nettype none

module flame_sweep_detector (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // input stream
  input  wire logic                             s_axis_tvalid,
  output      logic                             s_axis_tready,
  // tdata from bit 0: enable_value(1), now_ms(32), adc_sample(12), digital_level(1), pad(2)
  input  wire logic [fsd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: operation(3)
  input  wire logic [2:0]                       s_axis_tuser,
  // result stream
  output      logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // tdata from bit 0: current_angle(8), fire_detected(1), fire_direction(2),
  // fire_angle(8), raw_value(12), new_data(1), sweep_active(1),
  // detection_active(1), pad(6)
  output      logic [fsd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // configuration writes
  input  wire logic                             cfg_we,
  input  wire logic [2:0]                       cfg_index,
  input  wire logic [fsd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fsd_pkg::*;

  // setup registers
  angle_t                  min_angle;
  angle_t                  max_angle;
  angle_t                  step_degrees;
  logic [INTERVAL_W-1:0]   step_interval_ms;
  sample_t                 fire_threshold;
  logic [1:0]              sensing_mode;
  logic [INTERVAL_W-1:0]   confirm_ms;
  angle_t                  direction_center;

  // block state
  angle_t     scan_angle,      scan_angle_next;
  logic       sweep_rising,    sweep_rising_next;
  stamp_t     last_step_stamp, last_step_stamp_next;
  stamp_t     candidate_stamp, candidate_stamp_next;
  logic       detected_flag,   detected_flag_next;
  logic [1:0] direction_class, direction_class_next;
  angle_t     latched_angle,   latched_angle_next;
  sample_t    last_reading,    last_reading_next;
  logic       changed_flag,    changed_flag_next;
  logic       sweep_on,        sweep_on_next;
  logic       detect_on,       detect_on_next;

  // output and skid registers
  logic                  skid_valid;
  logic [OUT_DATA_W-1:0] skid_data;
  logic [OUT_DATA_W-1:0] result;

  // unpacked input fields
  op_t     op;
  logic    enable_value;
  stamp_t  now_ms;
  sample_t adc_sample;
  logic    digital_level;
  logic    in_accept;

  assign op            = op_t'(s_axis_tuser);
  assign enable_value  = s_axis_tdata[0];
  assign now_ms        = s_axis_tdata[32:1];
  assign adc_sample    = s_axis_tdata[44:33];
  assign digital_level = s_axis_tdata[45];

  assign s_axis_tready = ~skid_valid;
  assign in_accept     = s_axis_tvalid & s_axis_tready;

  // ---------------------------------------------------------------------------
  // configuration registers, with scan clamp when a sweep end moves
  // ---------------------------------------------------------------------------
  angle_t cfg_lo;
  angle_t cfg_hi;
  angle_t clamped_angle;
  logic   range_write;

  always_comb begin
    cfg_lo = (cfg_index == REG_MIN_ANGLE) ? cfg_data[ANGLE_W-1:0] : min_angle;
    cfg_hi = (cfg_index == REG_MAX_ANGLE) ? cfg_data[ANGLE_W-1:0] : max_angle;
    // lower bound first, then upper
    clamped_angle = (scan_angle < cfg_lo) ? cfg_lo : scan_angle;
    if (clamped_angle > cfg_hi) begin
      clamped_angle = cfg_hi;
    end
    range_write = cfg_we &&
                  (cfg_index == REG_MIN_ANGLE || cfg_index == REG_MAX_ANGLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_angle        <= RST_MIN_ANGLE;
      max_angle        <= RST_MAX_ANGLE;
      step_degrees     <= RST_STEP_DEGREES;
      step_interval_ms <= RST_STEP_INTERVAL;
      fire_threshold   <= RST_FIRE_THRESHOLD;
      sensing_mode     <= RST_SENSING_MODE;
      confirm_ms       <= RST_CONFIRM_MS;
      direction_center <= RST_DIR_CENTER;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_ANGLE:      min_angle        <= cfg_data[ANGLE_W-1:0];
        REG_MAX_ANGLE:      max_angle        <= cfg_data[ANGLE_W-1:0];
        REG_STEP_DEGREES:   step_degrees     <= cfg_data[ANGLE_W-1:0];
        REG_STEP_INTERVAL:  step_interval_ms <= cfg_data;
        REG_FIRE_THRESHOLD: fire_threshold   <= cfg_data[SAMPLE_BITS-1:0];
        REG_SENSING_MODE:   sensing_mode     <= cfg_data[1:0];
        REG_CONFIRM_MS:     confirm_ms       <= cfg_data;
        REG_DIR_CENTER:     direction_center <= cfg_data[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // tick path: sweep step, then flame qualification and confirmation
  // ---------------------------------------------------------------------------
  angle_t           tick_angle;
  logic             tick_rising;
  stamp_t           tick_step_stamp;
  logic [ANGLE_W:0] up_sum;
  logic [ANGLE_W:0] low_sum;
  stamp_t           since_step;
  logic             step_due;
  logic             fire;
  sample_t          tick_reading;
  stamp_t           tick_cand;
  stamp_t           since_cand;
  logic             det;
  logic [1:0]       tick_dir;
  angle_t           tick_latched;
  logic             tick_detected;
  logic             tick_changed;

  always_comb begin
    // sweep step, bouncing at either end
    tick_angle      = scan_angle;
    tick_rising     = sweep_rising;
    tick_step_stamp = last_step_stamp;
    up_sum     = {1'b0, scan_angle} + {1'b0, step_degrees};
    low_sum    = {1'b0, min_angle} + {1'b0, step_degrees};
    since_step = now_ms - last_step_stamp;
    step_due   = sweep_on && (since_step >= {{(STAMP_W-INTERVAL_W){1'b0}}, step_interval_ms});
    if (step_due) begin
      tick_step_stamp = now_ms;
      if (sweep_rising) begin
        if (up_sum >= {1'b0, max_angle}) begin
          tick_angle  = max_angle;
          tick_rising = 1'b0;
        end else begin
          tick_angle = up_sum[ANGLE_W-1:0];
        end
      end else begin
        if ({1'b0, scan_angle} <= low_sum) begin
          tick_angle  = min_angle;
          tick_rising = 1'b1;
        end else begin
          tick_angle = scan_angle - step_degrees;
        end
      end
    end

    // qualify the sample
    if (sensing_mode == SENSE_DIGITAL) begin
      fire         = ~digital_level;
      tick_reading = {{(SAMPLE_BITS-1){1'b0}}, ~digital_level};
    end else begin
      tick_reading = adc_sample;
      if (sensing_mode == SENSE_AT_MOST) begin
        fire = (adc_sample <= fire_threshold);
      end else begin
        fire = (adc_sample >= fire_threshold);
      end
    end

    // persistence check; a zero stamp means no candidate
    tick_cand = fire ? ((candidate_stamp == '0) ? now_ms : candidate_stamp) : '0;
    since_cand = now_ms - tick_cand;
    det = (tick_cand != '0) &&
          (since_cand >= {{(STAMP_W-INTERVAL_W){1'b0}}, confirm_ms});

    tick_latched = latched_angle;
    if (!detect_on) begin
      tick_cand     = '0;
      tick_dir      = DIR_NONE;
      tick_detected = 1'b0;
      tick_changed  = changed_flag | detected_flag;
    end else begin
      if (det) begin
        tick_latched = tick_angle;
        tick_dir     = class_of(tick_angle, direction_center);
      end else begin
        tick_dir = DIR_NONE;
      end
      tick_detected = det;
      tick_changed  = changed_flag | (det != detected_flag) | (tick_dir != direction_class);
    end
  end

  // ---------------------------------------------------------------------------
  // next state for one item
  // ---------------------------------------------------------------------------
  always_comb begin
    scan_angle_next      = scan_angle;
    sweep_rising_next    = sweep_rising;
    last_step_stamp_next = last_step_stamp;
    candidate_stamp_next = candidate_stamp;
    detected_flag_next   = detected_flag;
    direction_class_next = direction_class;
    latched_angle_next   = latched_angle;
    last_reading_next    = last_reading;
    changed_flag_next    = changed_flag;
    sweep_on_next        = sweep_on;
    detect_on_next       = detect_on;
    unique case (op)
      OP_TICK: begin
        scan_angle_next      = tick_angle;
        sweep_rising_next    = tick_rising;
        last_step_stamp_next = tick_step_stamp;
        candidate_stamp_next = tick_cand;
        detected_flag_next   = tick_detected;
        direction_class_next = tick_dir;
        latched_angle_next   = tick_latched;
        last_reading_next    = tick_reading;
        changed_flag_next    = tick_changed;
      end
      OP_SWEEP_EN: begin
        if (enable_value != sweep_on) begin
          sweep_on_next = enable_value;
          if (enable_value) begin
            scan_angle_next   = max_angle;
            sweep_rising_next = 1'b0;
          end
        end
      end
      OP_DETECT_EN: begin
        if (enable_value != detect_on) begin
          detect_on_next = enable_value;
          if (!enable_value) begin
            detected_flag_next   = 1'b0;
            changed_flag_next    = 1'b0;
            direction_class_next = DIR_NONE;
            candidate_stamp_next = '0;
          end
        end
      end
      OP_CENTER: begin
        scan_angle_next      = max_angle;
        latched_angle_next   = '0;
        direction_class_next = DIR_NONE;
        detected_flag_next   = 1'b0;
        candidate_stamp_next = '0;
        sweep_rising_next    = 1'b0;
      end
      OP_CLEAR: changed_flag_next = 1'b0;
      default: ;  // unused codes only return the current status
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_angle      <= RST_MAX_ANGLE;
      sweep_rising    <= 1'b0;
      last_step_stamp <= '0;
      candidate_stamp <= '0;
      detected_flag   <= 1'b0;
      direction_class <= DIR_NONE;
      latched_angle   <= '0;
      last_reading    <= '0;
      changed_flag    <= 1'b0;
      sweep_on        <= 1'b0;
      detect_on       <= 1'b0;
    end else if (range_write) begin
      scan_angle <= clamped_angle;
    end else if (in_accept) begin
      scan_angle      <= scan_angle_next;
      sweep_rising    <= sweep_rising_next;
      last_step_stamp <= last_step_stamp_next;
      candidate_stamp <= candidate_stamp_next;
      detected_flag   <= detected_flag_next;
      direction_class <= direction_class_next;
      latched_angle   <= latched_angle_next;
      last_reading    <= last_reading_next;
      changed_flag    <= changed_flag_next;
      sweep_on        <= sweep_on_next;
      detect_on       <= detect_on_next;
    end
  end

  // ---------------------------------------------------------------------------
  // result packing and output / skid registers
  // ---------------------------------------------------------------------------
  assign result = {6'b0, detect_on_next, sweep_on_next, changed_flag_next,
                   last_reading_next, latched_angle_next, direction_class_next,
                   detected_flag_next, scan_angle_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      if (skid_valid) begin
        // tready is low while the skid is full, so nothing new arrives here
        m_axis_tvalid <= 1'b1;
        skid_valid    <= 1'b0;
      end else begin
        m_axis_tvalid <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_axis_tvalid || m_axis_tready) begin
      if (skid_valid) begin
        m_axis_tdata <= skid_data;
      end else if (in_accept) begin
        m_axis_tdata <= result;
      end
    end else if (in_accept) begin
      skid_data <= result;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_axis_tvalid)
    else $error("skid register holds a result while the output register is empty");

  a_detect_has_dir: assert property (@(posedge clk) disable iff (rst)
    detected_flag == (direction_class != DIR_NONE))
    else $error("detection flag and direction class disagree");

  a_detect_needs_enable: assert property (@(posedge clk) disable iff (rst)
    !detect_on |-> (!detected_flag && candidate_stamp == '0))
    else $error("detection state held while detection is disabled");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !m_axis_tvalid) |=> m_axis_tvalid)
    else $error("accepted item did not reach the output register");

endmodule

`default_nettype wire
